// ===== rtl/pn_pkg.sv =====
`default_nettype none

package pn_pkg;

    localparam int unsigned SAMPLE_W   = 16;
    localparam int unsigned OUT_W      = 24;
    localparam int unsigned PASS_SHIFT = OUT_W - SAMPLE_W;
    localparam int unsigned CNT_W      = $clog2(OUT_W);

    // 1.0 in Q4.12.
    localparam logic [SAMPLE_W-1:0] ONE_Q12 = 16'd4096;

    localparam logic [OUT_W-1:0] OUT_POS_MAX = 24'h7F_FFFF;
    localparam logic [OUT_W-1:0] OUT_NEG_MAX = 24'h80_0000;

    localparam logic [CNT_W-1:0] LAST_BIT = CNT_W'(OUT_W - 1);

    localparam logic MODE_MEASURE = 1'b0;
    localparam logic MODE_SCALE   = 1'b1;

endpackage

`default_nettype wire

// ===== rtl/pn_if.sv =====
`default_nettype none

interface pn_in_if;
    logic                                 valid;
    logic                                 ready;
    logic                                 mode;
    logic                                 first;
    logic signed [pn_pkg::SAMPLE_W-1:0]   sample;

    modport source (output valid, output mode, output first, output sample, input ready);
    modport sink   (input valid, input mode, input first, input sample, output ready);
endinterface

interface pn_out_if;
    logic                                 valid;
    logic                                 ready;
    logic signed [pn_pkg::OUT_W-1:0]      out_sample;
    logic                                 was_scaled;

    modport source (output valid, output out_sample, output was_scaled, input ready);
    modport sink   (input valid, input out_sample, input was_scaled, output ready);
endinterface

`default_nettype wire

// ===== rtl/peak_normalizer_unit.sv =====
// Channel    Dir   Payload                          Handshake
// audio      in    mode, first, sample (Q4.12)      valid / ready
// result     out   out_sample (Q4.20), was_scaled   valid / ready
// cfg        in    cfg_wdata (only_if_too_high)     cfg_we, no wait
//
// A measure request produces no result.
// A divided scale request is loaded, then runs the restoring divider that
// yields one quotient bit per cycle, then writes the output register once
// that is free. A pass-through scale request goes from load straight to the write.
// Reset clears the peak, the mode bit and all control state.
// The output register holds a result while the sink stalls; a new request is
// accepted as soon as the block is back in ST_IDLE, even with a result still waiting.

`default_nettype none

module peak_normalizer_unit (
    input  wire logic     clk,
    input  wire logic     rst_n,
    pn_in_if.sink         audio,
    pn_out_if.source      result,
    input  wire logic     cfg_we,
    input  wire logic     cfg_wdata
);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_DIV   = 2'd1;
    localparam logic [1:0] ST_WRITE = 2'd2;

    logic [1:0]                    state_reg, state_next;
    logic [pn_pkg::CNT_W-1:0]      cnt_reg, cnt_next;
    logic [pn_pkg::SAMPLE_W-1:0]   peak_reg, peak_next;
    logic                          oith_reg;
    logic                          neg_reg, neg_next;
    logic                          ovf_reg, ovf_next;
    logic                          scaled_reg, scaled_next;
    logic [pn_pkg::OUT_W-1:0]      sr_reg, sr_next;
    logic [pn_pkg::SAMPLE_W-1:0]   rem_reg, rem_next;
    logic                          out_valid_reg, out_valid_next;
    logic [pn_pkg::OUT_W-1:0]      out_sample_reg, out_sample_next;
    logic                          out_scaled_reg, out_scaled_next;

    logic                          accept;
    logic                          in_neg;
    logic [pn_pkg::SAMPLE_W-1:0]   in_mag;
    logic                          pass;
    logic [pn_pkg::SAMPLE_W:0]     trial;
    logic                          qbit;
    logic                          write_out;
    logic [pn_pkg::OUT_W-1:0]      sat_value;

    assign accept = audio.valid && audio.ready;
    assign audio.ready = (state_reg == ST_IDLE);

    assign in_neg = audio.sample[pn_pkg::SAMPLE_W-1];
    assign in_mag = in_neg ? (~audio.sample + 1'b1) : audio.sample;

    assign pass = (peak_reg == '0) || (oith_reg && (peak_reg <= pn_pkg::ONE_Q12));

    assign trial = {rem_reg, sr_reg[pn_pkg::OUT_W-1]};
    assign qbit  = (trial >= {1'b0, peak_reg});

    assign write_out = (state_reg == ST_WRITE) && (!out_valid_reg || result.ready);

    // Saturate the unsigned quotient and apply the sample's sign; a pass-through value goes out unchanged.
    always_comb
    begin
        if (!scaled_reg)
        begin
            sat_value = sr_reg;
        end
        else if (neg_reg)
        begin
            if (ovf_reg || (sr_reg > pn_pkg::OUT_NEG_MAX))
                sat_value = pn_pkg::OUT_NEG_MAX;
            else
                sat_value = ~sr_reg + 1'b1;
        end
        else
        begin
            if (ovf_reg || sr_reg[pn_pkg::OUT_W-1])
                sat_value = pn_pkg::OUT_POS_MAX;
            else
                sat_value = sr_reg;
        end
    end

    always_comb
    begin
        state_next      = state_reg;
        cnt_next        = cnt_reg;
        peak_next       = peak_reg;
        neg_next        = neg_reg;
        ovf_next        = ovf_reg;
        scaled_next     = scaled_reg;
        sr_next         = sr_reg;
        rem_next        = rem_reg;
        out_valid_next  = out_valid_reg && !result.ready;
        out_sample_next = out_sample_reg;
        out_scaled_next = out_scaled_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (audio.mode == pn_pkg::MODE_MEASURE)
                    begin
                        if (audio.first || (in_mag > peak_reg))
                            peak_next = in_mag;
                    end
                    else if (pass)
                    begin
                        sr_next     = {audio.sample, {pn_pkg::PASS_SHIFT{1'b0}}};
                        neg_next    = 1'b0;
                        ovf_next    = 1'b0;
                        scaled_next = 1'b0;
                        state_next  = ST_WRITE;
                    end
                    else
                    begin
                        // The quotient needs more than 24 bits when mag >= 16 * peak.
                        ovf_next    = ({4'b0, in_mag} >= {peak_reg, 4'b0});
                        neg_next    = in_neg;
                        scaled_next = 1'b1;
                        rem_next    = {4'b0, in_mag[pn_pkg::SAMPLE_W-1:4]};
                        sr_next     = {in_mag[3:0], 20'b0};
                        cnt_next    = pn_pkg::LAST_BIT;
                        state_next  = ST_DIV;
                    end
                end
            end
            ST_DIV:
            begin
                rem_next = qbit ? 16'(trial - {1'b0, peak_reg}) : trial[pn_pkg::SAMPLE_W-1:0];
                sr_next  = {sr_reg[pn_pkg::OUT_W-2:0], qbit};
                cnt_next = cnt_reg - 1'b1;
                if (cnt_reg == '0)
                    state_next = ST_WRITE;
            end
            ST_WRITE:
            begin
                if (write_out)
                begin
                    out_valid_next  = 1'b1;
                    out_sample_next = sat_value;
                    out_scaled_next = scaled_reg;
                    state_next      = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            peak_reg      <= '0;
            oith_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            peak_reg      <= peak_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we)
                oith_reg <= cfg_wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        neg_reg        <= neg_next;
        ovf_reg        <= ovf_next;
        scaled_reg     <= scaled_next;
        sr_reg         <= sr_next;
        rem_reg        <= rem_next;
        out_sample_reg <= out_sample_next;
        out_scaled_reg <= out_scaled_next;
    end

    assign result.valid      = out_valid_reg;
    assign result.out_sample = out_sample_reg;
    assign result.was_scaled = out_scaled_reg;

    // Without overflow the partial remainder always stays below the divisor.
    a_rem_below_peak: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DIV && !ovf_reg) |-> (rem_reg < peak_reg))
        else $error("divider remainder not below peak");

    a_div_ends: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DIV && cnt_reg == '0) |=> (state_reg == ST_WRITE))
        else $error("divider did not finish after the last bit");

    a_measure_no_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && audio.mode == pn_pkg::MODE_MEASURE) |=> (state_reg == ST_IDLE))
        else $error("measure request left the block busy");

    // A pass-through result is the sample shifted up, so its low bits are zero.
    a_pass_low_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (result.valid && !result.was_scaled) |-> (result.out_sample[7:0] == 8'd0))
        else $error("pass-through result has nonzero fraction bits");

endmodule

`default_nettype wire

// ===== test/tb_peak_normalizer_unit.sv =====
typedef struct {
    logic signed [pn_pkg::OUT_W-1:0] out_sample;
    logic                            was_scaled;
} norm_result_t;

class norm_scoreboard;
    localparam int unsigned QUOT_SHIFT = pn_pkg::OUT_W - 4;

    bit                           high_only;
    logic [pn_pkg::SAMPLE_W-1:0]  peak;
    norm_result_t                 pending[$];
    int                           errors;
    int                           n_measure;
    int                           n_scale;
    int                           n_checked;

    function new();
        high_only = 1'b0;
        peak      = '0;
        errors    = 0;
        n_measure = 0;
        n_scale   = 0;
        n_checked = 0;
    endfunction

    function void note_request(logic m, logic f, logic signed [pn_pkg::SAMPLE_W-1:0] s);
        logic [pn_pkg::SAMPLE_W:0] mag;
        logic                      neg;
        logic [63:0]               q;
        norm_result_t              r;
        neg = s[pn_pkg::SAMPLE_W-1];
        mag = neg ? 17'h10000 - {1'b0, s} : {1'b0, s};
        if (m == pn_pkg::MODE_MEASURE)
        begin
            if (f || mag > {1'b0, peak})
                peak = mag[pn_pkg::SAMPLE_W-1:0];
            n_measure++;
            return;
        end
        n_scale++;
        if (peak == '0 || (high_only && peak <= pn_pkg::ONE_Q12))
        begin
            q = 64'(mag) << pn_pkg::PASS_SHIFT;
            r.was_scaled = 1'b0;
        end
        else
        begin
            q = (64'(mag) << QUOT_SHIFT) / 64'(peak);
            r.was_scaled = 1'b1;
        end
        // A scale sample of eight or more times the measured peak saturates the quotient.
        if (neg)
        begin
            if (q > 64'(pn_pkg::OUT_NEG_MAX))
                q = 64'(pn_pkg::OUT_NEG_MAX);
            r.out_sample = 24'(64'd0 - q);
        end
        else
        begin
            if (q > 64'(pn_pkg::OUT_POS_MAX))
                q = 64'(pn_pkg::OUT_POS_MAX);
            r.out_sample = q[pn_pkg::OUT_W-1:0];
        end
        pending = {pending, r};
    endfunction

    function void check_result(logic signed [pn_pkg::OUT_W-1:0] o, logic w);
        norm_result_t e;
        if (pending.size() == 0)
        begin
            $error("result with no request waiting: out_sample %0d, was_scaled %0d", o, w);
            errors++;
            return;
        end
        e = pending.pop_front();
        n_checked++;
        if (o !== e.out_sample)
        begin
            $error("out_sample mismatch: expected %0d, actual %0d", e.out_sample, o);
            errors++;
        end
        if (w !== e.was_scaled)
        begin
            $error("was_scaled mismatch: expected %0d, actual %0d", e.was_scaled, w);
            errors++;
        end
    endfunction
endclass

module tb_peak_normalizer_unit;

    localparam int STALL_LIMIT = 3000;
    localparam int RANDOM_ITEMS = 400;

    logic clk = 1'b0;
    logic rst_n;
    logic cfg_we;
    logic cfg_wdata;
    bit   calm;
    int   n_sent;
    int   n_cfg_writes;

    norm_scoreboard sb;

    pn_in_if  audio_ch();
    pn_out_if result_ch();

    peak_normalizer_unit u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .audio     (audio_ch),
        .result    (result_ch),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    always #10 clk = ~clk;

    function automatic int pick_gap();
        int r;
        if (calm)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    task automatic send(input logic m, input logic f,
                        input logic signed [pn_pkg::SAMPLE_W-1:0] s);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            audio_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        audio_ch.valid  <= 1'b1;
        audio_ch.mode   <= m;
        audio_ch.first  <= f;
        audio_ch.sample <= s;
        @(posedge clk);
        while (!audio_ch.ready) @(posedge clk);
        sb.note_request(m, f, s);
        n_sent++;
    endtask

    task automatic drain();
        audio_ch.valid <= 1'b0;
        while (sb.pending.size() != 0) @(posedge clk);
        // Measure requests produce no result, so give the block time to settle.
        repeat (30) @(posedge clk);
    endtask

    task automatic write_high_only(input bit v);
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(posedge clk);
        cfg_we <= 1'b0;
        sb.high_only = v;
        n_cfg_writes++;
    endtask

    always @(posedge clk)
    begin
        if (rst_n && result_ch.valid && result_ch.ready)
            sb.check_result(result_ch.out_sample, result_ch.was_scaled);
    end

    initial
    begin : sink_side
        int n;
        wait (rst_n);
        forever
        begin
            result_ch.ready <= 1'b1;
            n = calm ? 8 : $urandom_range(1, 12);
            repeat (n) @(posedge clk);
            n = pick_gap();
            if (n > 0)
            begin
                result_ch.ready <= 1'b0;
                repeat (n) @(posedge clk);
            end
        end
    end

    initial
    begin : watchdog
        int idle;
        idle = 0;
        while (idle < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((audio_ch.valid && audio_ch.ready) || (result_ch.valid && result_ch.ready))
                idle = 0;
            else
                idle++;
        end
        $display("No request or result accepted for %0d cycles.", STALL_LIMIT);
        $display("RESULT: ERROR");
        $finish;
    end

    initial
    begin : stimulus
        int directed_n;
        sb = new();
        calm = 1'b0;
        n_sent = 0;
        n_cfg_writes = 0;
        audio_ch.valid  = 1'b0;
        audio_ch.mode   = pn_pkg::MODE_MEASURE;
        audio_ch.first  = 1'b0;
        audio_ch.sample = '0;
        result_ch.ready = 1'b0;
        cfg_we    = 1'b0;
        cfg_wdata = 1'b0;
        rst_n     = 1'b0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        write_high_only(1'b0);

        // Zero peak after reset passes samples through; first is ignored in the scale pass.
        send(pn_pkg::MODE_SCALE, 1'b0, 16'sh7FFF);
        send(pn_pkg::MODE_SCALE, 1'b1, 16'sh8000);
        send(pn_pkg::MODE_MEASURE, 1'b1, 16'sh8000);
        send(pn_pkg::MODE_SCALE, 1'b0, 16'sh7FFF);
        send(pn_pkg::MODE_SCALE, 1'b0, 16'sh8000);
        send(pn_pkg::MODE_SCALE, 1'b0, 16'sh0000);
        // Peak of one LSB drives both saturation limits.
        send(pn_pkg::MODE_MEASURE, 1'b1, 16'sh0001);
        send(pn_pkg::MODE_SCALE, 1'b0, 16'sh7FFF);
        send(pn_pkg::MODE_SCALE, 1'b0, 16'sh8000);
        send(pn_pkg::MODE_SCALE, 1'b0, -16'sd1);
        send(pn_pkg::MODE_MEASURE, 1'b1, 16'sd100);
        send(pn_pkg::MODE_MEASURE, 1'b0, 16'sd3000);
        send(pn_pkg::MODE_MEASURE, 1'b0, -16'sd50);
        send(pn_pkg::MODE_SCALE, 1'b0, -16'sd3000);
        send(pn_pkg::MODE_SCALE, 1'b0, 16'sd1500);
        send(pn_pkg::MODE_MEASURE, 1'b1, 16'sd0);
        send(pn_pkg::MODE_SCALE, 1'b0, 16'sd1234);
        drain();
        write_high_only(1'b1);
        // Peak exactly at 1.0 is not too high; one LSB above it is.
        send(pn_pkg::MODE_MEASURE, 1'b1, 16'sd4096);
        send(pn_pkg::MODE_SCALE, 1'b0, -16'sd4096);
        send(pn_pkg::MODE_MEASURE, 1'b1, 16'sd4097);
        send(pn_pkg::MODE_SCALE, 1'b0, 16'sd4096);
        send(pn_pkg::MODE_MEASURE, 1'b1, -16'sd4096);
        send(pn_pkg::MODE_MEASURE, 1'b0, 16'sd4096);
        send(pn_pkg::MODE_SCALE, 1'b0, -16'sd1);
        send(pn_pkg::MODE_SCALE, 1'b0, 16'sd0);
        directed_n = n_sent;

        for (int p = 0; p < 4; p++)
        begin
            drain();
            write_high_only(p[0]);
            while (n_sent < directed_n + (p + 1) * (RANDOM_ITEMS / 4))
            begin : clip_pass
                logic signed [pn_pkg::SAMPLE_W-1:0] clip[$];
                logic signed [pn_pkg::SAMPLE_W-1:0] s;
                int len;
                int kind;
                int mag;
                bit broken;
                clip.delete();
                len  = ($urandom_range(0, 4) == 0) ? $urandom_range(7, 24) : $urandom_range(1, 6);
                kind = $urandom_range(0, 9);
                for (int i = 0; i < len; i++)
                begin
                    case (kind)
                        0, 1, 2, 3, 4: s = 16'($urandom);
                        5, 6:
                        begin
                            mag = $urandom_range(3900, 4300);
                            s = $urandom_range(0, 1) ? 16'(-mag) : 16'(mag);
                        end
                        7: s = 16'($urandom_range(0, 6)) - 16'sd3;
                        8: s = '0;
                        default: s = $urandom_range(0, 1) ? 16'sh8000 : 16'sh7FFF;
                    endcase
                    clip = {clip, s};
                end
                calm = ($urandom_range(0, 7) == 0);
                // A broken clip misses its first flag and may also restart in the middle.
                broken = ($urandom_range(0, 9) == 0);
                foreach (clip[i])
                    send(pn_pkg::MODE_MEASURE,
                         (i == 0) ? !broken : (broken && $urandom_range(0, 3) == 0),
                         clip[i]);
                foreach (clip[i])
                begin
                    if ($urandom_range(0, 6) == 0)
                        send(pn_pkg::MODE_SCALE, 1'($urandom), 16'($urandom));
                    send(pn_pkg::MODE_SCALE, ($urandom_range(0, 9) == 0), clip[i]);
                end
                if ($urandom_range(0, 9) == 0)
                    repeat ($urandom_range(1, 4)) send(1'($urandom), 1'($urandom), 16'($urandom));
                calm = 1'b0;
            end
        end
        drain();

        $display("Sent %0d requests (%0d measure, %0d scale) and checked %0d results,",
                 n_sent, sb.n_measure, sb.n_scale, sb.n_checked);
        $display("with %0d writes of the pass-through-when-quiet bit.", n_cfg_writes);
        if (sb.errors == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end
endmodule

// ===== filelist.f =====
rtl/pn_pkg.sv
rtl/pn_if.sv
rtl/peak_normalizer_unit.sv
test/tb_peak_normalizer_unit.sv
